FILE: rtl/core/isp_pkg.sv
// Shared types and constants for the instance-block stream parser.
package isp_pkg;

	localparam int unsigned TDATA_W = 144;
	localparam logic [31:0] MAGIC_WORD = 32'h900d_f00d;

	localparam logic [2:0] KIND_RANGE   = 3'd0;
	localparam logic [2:0] KIND_LAYER   = 3'd1;
	localparam logic [2:0] KIND_SMIN    = 3'd2;
	localparam logic [2:0] KIND_SMAX    = 3'd3;
	localparam logic [2:0] KIND_INST    = 3'd4;
	localparam logic [2:0] KIND_DONE    = 3'd5;
	localparam logic [2:0] KIND_ERROR   = 3'd6;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_VERSION  = 3'd1;
	localparam logic [2:0] ERR_SCALE    = 3'd2;
	localparam logic [2:0] ERR_FORMAT   = 3'd3;
	localparam logic [2:0] ERR_MAGIC    = 3'd4;

	localparam logic [3:0] LEN_WORD     = 4'd4;
	localparam logic [3:0] LEN_HALF     = 4'd2;
	localparam logic [3:0] LEN_RECORD   = 4'd10;

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_LCOUNT = 10'b00_0000_0010,
		PH_RANGE  = 10'b00_0000_0100,
		PH_LID    = 10'b00_0000_1000,
		PH_ICOUNT = 10'b00_0001_0000,
		PH_SMIN   = 10'b00_0010_0000,
		PH_SMAX   = 10'b00_0100_0000,
		PH_FORMAT = 10'b00_1000_0000,
		PH_INST   = 10'b01_0000_0000,
		PH_MAGIC  = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] layer_ident;
		logic [31:0] word;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [7:0]  scale_code;
		logic [7:0]  rot_x;
		logic [7:0]  rot_y;
		logic [7:0]  rot_z;
		logic [7:0]  rot_w;
		logic [2:0]  error_code;
	} result_t;

endpackage

FILE: rtl/core/isp_parser.sv
// Byte-wise parser state machine that turns each accepted byte into at most one result.
module isp_parser import isp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  logic       in_start,
	output logic       res_valid,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d, cnt_inc;
	logic [31:0] gather_q, gather_d, gather_next;
	logic [7:0]  layers_q, layers_d, layers_dec;
	logic [15:0] inst_q, inst_d, inst_dec;
	logic [15:0] layer_id_q, layer_id_d;
	logic [31:0] smin_q, smin_d;
	logic [7:0]  rec_q [LEN_RECORD];
	logic        rec_we;

	function automatic logic is_nan(input logic [31:0] b);
		is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic [31:0] order_key(input logic [31:0] b);
		order_key = b[31] ? ~b : {1'b1, b[30:0]};
	endfunction

	// IEEE ordered a < b on raw single-precision bits; signed zeros are equal.
	function automatic logic float_less(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b))
			float_less = 1'b0;
		else if ((a[30:0] | b[30:0]) == 31'd0)
			float_less = 1'b0;
		else
			float_less = order_key(a) < order_key(b);
	endfunction

	assign cnt_inc     = cnt_q + 4'd1;
	assign gather_next = {gather_q[23:0], in_byte};
	assign layers_dec  = layers_q - 8'd1;
	assign inst_dec    = inst_q - 16'd1;

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		gather_d   = gather_q;
		layers_d   = layers_q;
		inst_d     = inst_q;
		layer_id_d = layer_id_q;
		smin_d     = smin_q;
		rec_we     = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		res.layer_ident = layer_id_q;

		if (in_fire) begin
			if (in_start) begin
				// A block start restarts the parser from a cleared state.
				cnt_d      = '0;
				gather_d   = '0;
				layers_d   = '0;
				inst_d     = '0;
				layer_id_d = '0;
				smin_d     = '0;
				res.layer_ident = '0;
				if (in_byte != 8'd0) begin
					phase_d        = PH_IDLE;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_VERSION;
				end else begin
					phase_d = PH_LCOUNT;
				end
			end else begin
				case (phase_q)
					PH_LCOUNT: begin
						layers_d = in_byte;
						phase_d  = PH_RANGE;
					end
					PH_RANGE: begin
						if (cnt_inc >= LEN_WORD) begin
							cnt_d     = '0;
							gather_d  = '0;
							phase_d   = (layers_q == 8'd0) ? PH_MAGIC : PH_LID;
							res_valid = 1'b1;
							res.kind  = KIND_RANGE;
							res.word  = gather_next;
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					PH_LID: begin
						if (cnt_inc >= LEN_HALF) begin
							cnt_d      = '0;
							gather_d   = '0;
							layer_id_d = gather_next[15:0];
							phase_d    = PH_ICOUNT;
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					PH_ICOUNT: begin
						if (cnt_inc >= LEN_HALF) begin
							cnt_d     = '0;
							gather_d  = '0;
							inst_d    = gather_next[15:0];
							phase_d   = PH_SMIN;
							res_valid = 1'b1;
							res.kind  = KIND_LAYER;
							res.word  = {16'd0, gather_next[15:0]};
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					PH_SMIN: begin
						if (cnt_inc >= LEN_WORD) begin
							cnt_d     = '0;
							gather_d  = '0;
							smin_d    = gather_next;
							phase_d   = PH_SMAX;
							res_valid = 1'b1;
							res.kind  = KIND_SMIN;
							res.word  = gather_next;
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					PH_SMAX: begin
						if (cnt_inc >= LEN_WORD) begin
							cnt_d     = '0;
							gather_d  = '0;
							res_valid = 1'b1;
							if (float_less(gather_next, smin_q)) begin
								phase_d        = PH_IDLE;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_SCALE;
							end else begin
								phase_d  = PH_FORMAT;
								res.kind = KIND_SMAX;
								res.word = gather_next;
							end
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					PH_FORMAT: begin
						if (in_byte != 8'd0) begin
							phase_d        = PH_IDLE;
							res_valid      = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_FORMAT;
						end else if (inst_q == 16'd0) begin
							layers_d = layers_dec;
							phase_d  = (layers_dec == 8'd0) ? PH_MAGIC : PH_LID;
						end else begin
							phase_d = PH_INST;
						end
					end
					PH_INST: begin
						if (cnt_q < LEN_RECORD) begin
							rec_we = 1'b1;
							cnt_d  = cnt_inc;
						end else begin
							// The eleventh byte completes the record and goes out directly.
							cnt_d          = '0;
							res_valid      = 1'b1;
							res.kind       = KIND_INST;
							res.pos_x      = {rec_q[0], rec_q[1]};
							res.pos_y      = {rec_q[2], rec_q[3]};
							res.pos_z      = {rec_q[4], rec_q[5]};
							res.scale_code = rec_q[6];
							res.rot_x      = rec_q[7];
							res.rot_y      = rec_q[8];
							res.rot_z      = rec_q[9];
							res.rot_w      = in_byte;
							inst_d         = inst_dec;
							if (inst_dec == 16'd0) begin
								layers_d = layers_dec;
								phase_d  = (layers_dec == 8'd0) ? PH_MAGIC : PH_LID;
							end
						end
					end
					PH_MAGIC: begin
						if (cnt_inc >= LEN_WORD) begin
							cnt_d     = '0;
							gather_d  = '0;
							phase_d   = PH_IDLE;
							res_valid = 1'b1;
							if (gather_next != MAGIC_WORD) begin
								res.kind       = KIND_ERROR;
								res.error_code = ERR_MAGIC;
							end else begin
								res.kind = KIND_DONE;
							end
						end else begin
							cnt_d    = cnt_inc;
							gather_d = gather_next;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			gather_q   <= '0;
			layers_q   <= '0;
			inst_q     <= '0;
			layer_id_q <= '0;
			smin_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			gather_q   <= gather_d;
			layers_q   <= layers_d;
			inst_q     <= inst_d;
			layer_id_q <= layer_id_d;
			smin_q     <= smin_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_q[cnt_q] <= in_byte;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_ERROR) |-> (res.error_code != ERR_NONE))
		else $error("error result without an error code");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((res.kind == KIND_ERROR) || (res.kind == KIND_DONE))
		|=> (phase_q == PH_IDLE))
		else $error("parser did not return to idle after end of block");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_INST) |-> (cnt_q <= LEN_RECORD))
		else $error("record byte counter ran past the record length");

endmodule

FILE: rtl/core/isp_out_buf.sv
// Two-entry output register with skid stage between the parser and the result stream.
module isp_out_buf import isp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid word held while the output register is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && main_valid_q && !out_ready |=> skid_valid_q)
		else $error("word pushed under a stall was not caught by the skid stage");

endmodule

FILE: rtl/core/instance_block_stream_parser_top.sv
// Top level of the instance-block stream parser.
//
// The s_axis channel carries one byte of a serialized instance block per word;
// s_axis_tuser high marks the version byte of a new block and restarts the parser.
// The m_axis channel carries parse results: m_axis_tuser holds the result kind
// and m_axis_tdata the layer id, word, instance record and error code.
// A byte that completes a field has its result registered in the output stage
// before it shows on m_axis; bytes that complete nothing give no result.
// Throughput is one byte per cycle while s_axis_tready is high, set by the parser
// state update, which works on each byte in the cycle it is accepted.
// After reset the parser is idle and waits for a block start; bytes without one
// are dropped. The output stage is empty.
// When the receiver stalls, one result waits on m_axis and a second is held in a
// skid register; s_axis_tready falls only while the skid register is full.
// Errors send the parser back to idle until the next block start.
module instance_block_stream_parser_top import isp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // [7:0] data_byte
	input  logic               s_axis_tuser,  // [0] block_start
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [15:0] layer_ident, [47:16] word, [63:48] pos_x, [79:64] pos_y, [95:80] pos_z,
	// [103:96] scale_code, [111:104] rot_x, [119:112] rot_y, [127:120] rot_z,
	// [135:128] rot_w, [138:136] error_code, [143:139] zero
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic [2:0]         m_axis_tuser   // [2:0] kind
);

	logic    in_fire;
	logic    res_valid;
	result_t res, out_res;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	isp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_byte   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	isp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {5'd0, out_res.error_code, out_res.rot_w, out_res.rot_z,
		out_res.rot_y, out_res.rot_x, out_res.scale_code, out_res.pos_z,
		out_res.pos_y, out_res.pos_x, out_res.word, out_res.layer_ident};

endmodule
